/* design/clsrng_pkg.sv */
// Shared constants, word and product types and modular fold for the combined shuffle generator.
`timescale 1ns / 1ps

package clsrng_pkg;

	localparam int VAL_W = 31;
	localparam int MULC_W = 16;
	localparam int PROD_W = VAL_W + MULC_W;
	localparam int FOLD_W = 8;

	typedef logic [VAL_W-1:0] val_t;
	typedef logic [PROD_W-1:0] prod_t;

	localparam val_t MOD_ONE = 31'd2147483563;
	localparam val_t MOD_TWO = 31'd2147483399;
	localparam logic [MULC_W-1:0] MUL_ONE = 16'd40014;
	localparam logic [MULC_W-1:0] MUL_TWO = 16'd40692;
	// 2^31 mod each modulus
	localparam logic [FOLD_W-1:0] FOLD_ONE = 8'd85;
	localparam logic [FOLD_W-1:0] FOLD_TWO = 8'd249;
	localparam val_t TOP_VALUE = 31'd2147483562;
	localparam val_t GEN_ONE_RESET = 31'd1;
	localparam val_t GEN_TWO_RESET = 31'd123456789;

	localparam logic REQ_DRAW = 1'b0;
	localparam logic REQ_SEED = 1'b1;

	// prod mod m, where 2^31 == fold (mod m) and the product is below 2^47
	function automatic val_t mod_fold(input prod_t prod, input logic [FOLD_W-1:0] fold,
			input val_t m);
		logic [VAL_W:0] t;
		t = (VAL_W+1)'(prod[PROD_W-1:VAL_W] * fold) + (VAL_W+1)'(prod[VAL_W-1:0]);
		if (t >= {1'b0, m}) begin
			t = t - {1'b0, m};
		end
		return t[VAL_W-1:0];
	endfunction

endpackage

/* design/combined_lcg_shuffle_rng_unit.sv */
// Top level: two multiplicative congruential generators combined through a shuffle table.
`timescale 1ns / 1ps

// Combined random generator with a Bays-Durham shuffle table of TABLE_DEPTH
// words. Each accepted request returns exactly one word in 1..2147483562;
// divide by 2147483563 for a uniform deviate. A draw (req_type 0) steps both
// generators, reads the table slot picked by the previous output, returns
// that entry minus the second generator (wrapped) and stores the new first
// generator value in the slot. A reseed (req_type 1) loads both generators
// with seed_value (0 taken as 1), steps the first one TABLE_DEPTH+8 times
// while filling the table, then draws. A draw runs through ST_DRAW_RED,
// ST_DRAW_READ and ST_DRAW_MIX, stalling in ST_DRAW_MIX while the output
// register holds an untaken word; a reseed first runs the warmup loop, one
// ST_SEED_MUL, ST_SEED_RED pair per step, and ST_DRAW_MUL. The table is a
// single-port-write, registered-read memory, so the slot read is registered
// in ST_DRAW_READ and the mix and the write-back share ST_DRAW_MIX. The slot
// index comes from a two-stage reciprocal divider that tracks the last
// output. Input is taken whenever the sequencer is idle, even while the
// last result still waits in the output register. After reset the table
// reads as zeros (per-entry valid bits) and no seeding is implied.
module combined_lcg_shuffle_rng_unit #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   req_type,
	input  clsrng_pkg::val_t       seed_value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output clsrng_pkg::val_t       random_value
);
	import clsrng_pkg::*;

	localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int WARM = TABLE_DEPTH + 8;
	localparam int CNT_W = $clog2(WARM);
	// slot = out / SLOT_DIV, estimated from the top bits then corrected once
	localparam longint unsigned SLOT_DIV = 64'd1 + 64'(TOP_VALUE) / 64'(TABLE_DEPTH);
	localparam longint unsigned RECIP = (64'd1 << 32) / SLOT_DIV;
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int Q_W = SLOT_W + 1;
	localparam int EST_SH = 16;
	localparam int DP_W = EST_SH + Q_W + RECIP_W;
	localparam val_t SLOT_DIV_V = VAL_W'(SLOT_DIV);
	localparam logic [Q_W-1:0] LAST_SLOT = Q_W'(TABLE_DEPTH - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED_MUL,
		ST_SEED_RED,
		ST_DRAW_MUL,
		ST_DRAW_RED,
		ST_DRAW_READ,
		ST_DRAW_MIX
	} state_t;

	state_t state_q;
	val_t gen_one_q, gen_two_q, shuffle_out_q;
	logic [CNT_W-1:0] cnt_q;
	logic out_valid_q;
	val_t random_value_q;

	// free-running products of the current generator words
	prod_t prod_one_q, prod_two_q;
	val_t fold_one, fold_two;

	// slot divider
	logic [DP_W-1:0] est_prod;
	logic [Q_W-1:0] q0_q;
	val_t q0_mul, q0_rem;
	logic [Q_W-1:0] q1, q1_sat;
	logic [SLOT_W-1:0] slot_q;

	// shuffle table
	val_t mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	val_t rd_q;
	logic rd_valid_q;
	val_t rd_word;
	logic rd_en, wr_en;
	logic [SLOT_W-1:0] wr_addr;
	val_t wr_data;
	logic out_free;
	val_t mix_word;
	val_t seed_eff;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign random_value = random_value_q;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		prod_one_q <= PROD_W'(gen_one_q) * PROD_W'(MUL_ONE);
		prod_two_q <= PROD_W'(gen_two_q) * PROD_W'(MUL_TWO);
	end

	assign fold_one = mod_fold(prod_one_q, FOLD_ONE, MOD_ONE);
	assign fold_two = mod_fold(prod_two_q, FOLD_TWO, MOD_TWO);

	// divider stage 1: estimate, never above the true quotient, at most one below
	assign est_prod = DP_W'(shuffle_out_q[VAL_W-1:EST_SH]) * DP_W'(RECIP);

	// divider stage 2: one correction step, then clamp to the table
	always_comb begin
		q0_mul = VAL_W'(VAL_W'(q0_q) * SLOT_DIV_V);
		q0_rem = shuffle_out_q - q0_mul;
		q1 = (q0_rem >= SLOT_DIV_V) ? q0_q + 1'b1 : q0_q;
		q1_sat = (q1 > LAST_SLOT) ? LAST_SLOT : q1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q0_q <= '0;
			slot_q <= '0;
		end else begin
			q0_q <= est_prod[EST_SH +: Q_W];
			slot_q <= q1_sat[SLOT_W-1:0];
		end
	end

	// table port control
	always_comb begin
		rd_en = (state_q == ST_DRAW_READ);
		wr_en = 1'b0;
		wr_addr = slot_q;
		wr_data = gen_one_q;
		unique case (state_q)
			ST_SEED_RED: begin
				wr_en = (cnt_q < CNT_W'(TABLE_DEPTH));
				wr_addr = cnt_q[SLOT_W-1:0];
				wr_data = fold_one;
			end
			ST_DRAW_MIX: begin
				wr_en = out_free;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[slot_q];
			end
		end
	end

	// never-written entries read as zero
	assign rd_word = rd_valid_q ? rd_q : '0;

	// entry minus second generator, wrapped into 1..TOP_VALUE
	always_comb begin
		if (rd_word > gen_two_q) begin
			mix_word = rd_word - gen_two_q;
		end else begin
			mix_word = VAL_W'((VAL_W+1)'(rd_word) + (VAL_W+1)'(TOP_VALUE)
				- (VAL_W+1)'(gen_two_q));
		end
	end

	assign seed_eff = (seed_value == '0) ? val_t'(1) : seed_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gen_one_q <= GEN_ONE_RESET;
			gen_two_q <= GEN_TWO_RESET;
			shuffle_out_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			random_value_q <= '0;
		end else begin
			// a new word replaces a taken one in the same cycle
			if (state_q == ST_DRAW_MIX && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (req_type == REQ_SEED) begin
							gen_one_q <= seed_eff;
							gen_two_q <= seed_eff;
							cnt_q <= CNT_W'(WARM - 1);
							state_q <= ST_SEED_MUL;
						end else begin
							// products already track the idle generators
							state_q <= ST_DRAW_RED;
						end
					end
				end
				ST_SEED_MUL: begin
					state_q <= ST_SEED_RED;
				end
				ST_SEED_RED: begin
					gen_one_q <= fold_one;
					if (cnt_q == '0) begin
						// last warmup value sits in entry 0 and seeds the slot pick
						shuffle_out_q <= fold_one;
						state_q <= ST_DRAW_MUL;
					end else begin
						cnt_q <= cnt_q - 1'b1;
						state_q <= ST_SEED_MUL;
					end
				end
				ST_DRAW_MUL: begin
					state_q <= ST_DRAW_RED;
				end
				ST_DRAW_RED: begin
					gen_one_q <= fold_one;
					gen_two_q <= fold_two;
					state_q <= ST_DRAW_READ;
				end
				ST_DRAW_READ: begin
					state_q <= ST_DRAW_MIX;
				end
				ST_DRAW_MIX: begin
					if (out_free) begin
						shuffle_out_q <= mix_word;
						random_value_q <= mix_word;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* bench/tb_combined_lcg_shuffle_rng_unit.sv */
// Self-checking bench for the combined LCG / shuffle-table random generator.
`timescale 1ns / 1ps

// Drives draw and reseed requests through the request channel and checks
// every returned word against a local model of the generator pair and the
// shuffle table. Stimulus is a short directed table followed by a long run
// of random requests. Both channel sides idle at random, with burst runs
// of no idling. The receiver does long hold-offs to back the block up, and
// the sender stops to let all pending words drain.
module tb_combined_lcg_shuffle_rng_unit;
	import clsrng_pkg::*;

	localparam int TABLE_DEPTH = 32;
	localparam int CLK_PERIOD = 4;
	localparam int RESET_CYCLES = 10;
	localparam int RANDOM_ITEMS = 1680;
	// covers a full reseed, plus a margin for the tail
	localparam int DRAIN_CYCLES = 2 * (TABLE_DEPTH + 8) + 20;
	localparam int LONG_HOLD = 400;
	localparam int HOLD_AT_A = 500;
	localparam int HOLD_AT_B = 1400;
	localparam int LIMIT_CYCLES = 1000000;
	// width of the output range mapped onto one table slot
	localparam longint unsigned SLOT_SPAN = 64'd1 + 64'(TOP_VALUE) / 64'(TABLE_DEPTH);

	// one directed request; pinned rows carry a hand-worked expected word
	typedef struct packed {
		logic req;
		val_t seed;
		logic pinned;
		val_t pinned_word;
	} stim_row_t;

	localparam int N_DIRECTED = 19;
	stim_row_t directed_rows [N_DIRECTED] = '{
		// first draw out of reset: zero table, slot 0, so the word is
		// TOP_VALUE minus the second generator stepped once from 123456789
		'{REQ_DRAW, 31'd0,          1'b1, 31'd1407495835},
		// seed field must be ignored on draws
		'{REQ_DRAW, 31'h7FFFFFFF,   1'b0, 31'd0},
		'{REQ_DRAW, 31'h2AAAAAAA,   1'b0, 31'd0},
		// zero seed behaves as one
		'{REQ_SEED, 31'd0,          1'b0, 31'd0},
		'{REQ_DRAW, 31'd0,          1'b0, 31'd0},
		'{REQ_SEED, 31'd1,          1'b0, 31'd0},
		'{REQ_SEED, 31'h7FFFFFFF,   1'b0, 31'd0},
		'{REQ_DRAW, 31'h55555555,   1'b0, 31'd0},
		// seed equal to the first modulus: first generator pinned at zero,
		// table all zero, word is TOP_VALUE minus 164*40692
		'{REQ_SEED, MOD_ONE,        1'b1, 31'd2140810074},
		'{REQ_DRAW, 31'd0,          1'b0, 31'd0},
		'{REQ_DRAW, 31'd0,          1'b0, 31'd0},
		// seed equal to the second modulus: second generator pinned at zero
		'{REQ_SEED, MOD_TWO,        1'b0, 31'd0},
		'{REQ_DRAW, 31'd0,          1'b0, 31'd0},
		'{REQ_DRAW, 31'd0,          1'b0, 31'd0},
		// between the two moduli, then above both
		'{REQ_SEED, 31'd2147483500, 1'b0, 31'd0},
		'{REQ_SEED, 31'd2147483600, 1'b0, 31'd0},
		'{REQ_SEED, 31'h2AAAAAAA,   1'b0, 31'd0},
		'{REQ_SEED, 31'h55555555,   1'b0, 31'd0},
		'{REQ_DRAW, 31'd0,          1'b0, 31'd0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic req_type;
	val_t seed_value;
	logic out_valid;
	logic out_ready;
	val_t random_value;

	combined_lcg_shuffle_rng_unit #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.seed_value(seed_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.random_value(random_value)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ---------------------------------------------------------------
	// Generator model: both congruential streams, the last output word
	// and the shuffle table, advanced once per accepted request.
	// ---------------------------------------------------------------
	val_t lcg_a;
	val_t lcg_b;
	val_t last_word;
	val_t shuffle_mem [TABLE_DEPTH];

	val_t pending_words [$];
	int errors = 0;
	int cycles = 0;
	int tx_run = 0;
	int rx_run = 0;
	int words_taken = 0;
	val_t head_word;

	// exact x*a mod m; 31x16 bits fits easily in 64
	function automatic val_t mulmod(input val_t x, input logic [MULC_W-1:0] a, input val_t m);
		longint unsigned p;
		p = 64'(x) * 64'(a);
		return val_t'(p % 64'(m));
	endfunction

	function automatic void model_reset();
		lcg_a = GEN_ONE_RESET;
		lcg_b = GEN_TWO_RESET;
		last_word = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			shuffle_mem[i] = '0;
		end
	endfunction

	// Applies one request to the model and returns the word it yields.
	function automatic val_t next_random_word(input logic req, input val_t seed);
		val_t s;
		longint unsigned slot;
		longint mix;
		if (req == REQ_SEED) begin
			s = (seed == '0) ? val_t'(1) : seed;
			lcg_a = s;
			lcg_b = s;
			// warmup: eight throwaway steps, then fill the table top down
			for (int n = TABLE_DEPTH + 7; n >= 0; n--) begin
				lcg_a = mulmod(lcg_a, MUL_ONE, MOD_ONE);
				if (n < TABLE_DEPTH) begin
					shuffle_mem[n] = lcg_a;
				end
			end
			last_word = shuffle_mem[0];
		end
		lcg_a = mulmod(lcg_a, MUL_ONE, MOD_ONE);
		lcg_b = mulmod(lcg_b, MUL_TWO, MOD_TWO);
		slot = 64'(last_word) / SLOT_SPAN;
		if (slot >= TABLE_DEPTH) begin
			slot = TABLE_DEPTH - 1;
		end
		mix = longint'(shuffle_mem[slot]) - longint'(lcg_b);
		shuffle_mem[slot] = lcg_a;
		if (mix < 1) begin
			mix = mix + longint'(TOP_VALUE);
		end
		last_word = val_t'(mix);
		return last_word;
	endfunction

	// Idle gap for one word: mostly a random gap, with occasional runs
	// of back-to-back words.
	function automatic int pick_gap(inout int run_left);
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			run_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 11);
	endfunction

	// Seeds lean on the corners: tiny values, around each modulus, the top
	// of the 31-bit range, and plain random words.
	function automatic val_t pick_seed();
		case ($urandom_range(0, 7))
			0: return val_t'($urandom_range(0, 3));
			1: return MOD_ONE - val_t'(3) + val_t'($urandom_range(0, 6));
			2: return MOD_TWO - val_t'(3) + val_t'($urandom_range(0, 6));
			3: return val_t'(31'h7FFFFFFF) - val_t'($urandom_range(0, 3));
			default: return val_t'($urandom());
		endcase
	endfunction

	// Offers one request word and holds it until taken; the expected
	// result is queued at the accepting edge.
	task automatic offer_word(input logic req, input val_t seed, input logic pinned,
			input val_t pinned_word);
		int gap;
		val_t want;
		gap = pick_gap(tx_run);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		seed_value <= seed;
		do @(posedge clk); while (!(in_valid && in_ready));
		want = next_random_word(req, seed);
		pending_words.push_back(pinned ? pinned_word : want);
	endtask

	// Sender goes quiet until every queued word has come back.
	task automatic wait_all_returned();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_words.size() != 0);
	endtask

	// ---------------------------------------------------------------
	// Receiver: random ready gaps, plus two long hold-offs so the output
	// register fills and the block has to stall its request side.
	// ---------------------------------------------------------------
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = pick_gap(rx_run);
			if (words_taken == HOLD_AT_A || words_taken == HOLD_AT_B) begin
				gap = LONG_HOLD;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			words_taken++;
		end
	end

	// Result check: every word taken is compared with the oldest pending one.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, got %0d", $time, random_value);
				errors++;
			end else begin
				head_word = pending_words.pop_front();
				if (random_value !== head_word) begin
					$display("%0t: random_value mismatch, expected %0d, got %0d",
						$time, head_word, random_value);
					errors++;
				end
			end
		end
	end

	// Watchdog on a cycle count.
	initial begin
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("** combined_lcg_shuffle_rng_unit: FAILED **");
		$finish;
	end

	// ---------------------------------------------------------------
	// Main sequence.
	// ---------------------------------------------------------------
	initial begin
		logic req;
		val_t seed;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_DRAW;
		seed_value = '0;
		model_reset();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		for (int i = 0; i < N_DIRECTED; i++) begin
			offer_word(directed_rows[i].req, directed_rows[i].seed,
				directed_rows[i].pinned, directed_rows[i].pinned_word);
		end
		wait_all_returned();

		// random run: mostly draws with random (ignored) seed bits, and
		// reseeds about one in sixteen so each seed is followed by a
		// stretch of draws that walks the freshly filled table
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2) begin
				wait_all_returned();
			end
			req = ($urandom_range(0, 15) == 0) ? REQ_SEED : REQ_DRAW;
			seed = (req == REQ_SEED) ? pick_seed() : val_t'($urandom());
			offer_word(req, seed, 1'b0, '0);
		end
		wait_all_returned();
		// catch any stray word after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("** combined_lcg_shuffle_rng_unit: PASSED **");
		end else begin
			$display("** combined_lcg_shuffle_rng_unit: FAILED **");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/clsrng_pkg.sv
design/combined_lcg_shuffle_rng_unit.sv
bench/tb_combined_lcg_shuffle_rng_unit.sv
